### hw/rtl/gspr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gspr_pkg
// Types, constants and arithmetic helpers shared by the regulator pipeline.
// ----------------------------------------------------------------------------
package gspr_pkg;

   localparam int PRES_W  = 24;
   localparam int ERR_W   = PRES_W + 1;
   localparam int WORD_W  = 32;
   localparam int DIV_W   = WORD_W + 8;
   localparam int ANGLE_W = 10;
   localparam int PROD_W  = WORD_W + ERR_W;
   localparam int SUM_W   = WORD_W + 1;
   localparam int TEN_W   = SUM_W + 4;

   localparam logic [ANGLE_W-1:0] MIN_OPEN_ANGLE = 10'd0;
   localparam logic [ANGLE_W-1:0] MAX_OPEN_ANGLE = 10'd850;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      REG_FF_BASE  = 3'd0,
      REG_FF_ALPHA = 3'd1,
      REG_FF_MIN   = 3'd2,
      REG_FF_MAX   = 3'd3,
      REG_KP_BASE  = 3'd4,
      REG_KP_BETA  = 3'd5,
      REG_KP_MIN   = 3'd6,
      REG_KP_MAX   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] ff_base;
      logic signed [WORD_W-1:0] ff_alpha;
      logic signed [WORD_W-1:0] ff_min;
      logic signed [WORD_W-1:0] ff_max;
      logic signed [WORD_W-1:0] kp_base;
      logic signed [WORD_W-1:0] kp_beta;
      logic signed [WORD_W-1:0] kp_min;
      logic signed [WORD_W-1:0] kp_max;
   } cfg_type;

   typedef struct packed {
      logic [PRES_W-1:0] rem;
      logic [DIV_W-1:0]  nq;
   } lane_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic [PRES_W-1:0]       pres;
   } side_type;

   typedef struct packed {
      lane_type ff;
      lane_type kp;
      side_type side;
   } div_stage_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]       angle;
      logic signed [WORD_W-1:0] pterm;
   } rsp_type;

   // one restoring division step: next dividend bit in, one quotient bit out
   function automatic lane_type div_step(lane_type l, logic [PRES_W-1:0] d);
      logic [PRES_W:0] t;
      logic [PRES_W:0] diff;
      logic            ge;
      lane_type        r;
      t    = {l.rem, l.nq[DIV_W-1]};
      diff = t - {1'b0, d};
      ge   = (t >= {1'b0, d});
      r.rem = ge ? diff[PRES_W-1:0] : t[PRES_W-1:0];
      r.nq  = {l.nq[DIV_W-2:0], ge};
      return r;
   endfunction

   function automatic logic [DIV_W-1:0] coef_mag(logic signed [WORD_W-1:0] c);
      logic [WORD_W-1:0] m;
      m = c[WORD_W-1] ? WORD_W'(-c) : WORD_W'(c);
      return {m, 8'd0};
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_sum(logic signed [SUM_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v[SUM_W-1] != v[SUM_W-2]) begin
         r = v[SUM_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

   // signed quotient from magnitude, saturated; zero divisor takes coef sign
   function automatic logic signed [WORD_W-1:0] sat_quo(logic [DIV_W-1:0] q,
         logic signed [WORD_W-1:0] coef, logic pres_zero);
      logic signed [WORD_W-1:0] r;
      logic                     neg;
      neg = coef[WORD_W-1];
      if (pres_zero) begin
         if (neg) begin
            r = WORD_MIN;
         end else if (coef != '0) begin
            r = WORD_MAX;
         end else begin
            r = '0;
         end
      end else if (neg) begin
         if (q > {{(DIV_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}}) begin
            r = WORD_MIN;
         end else begin
            r = WORD_W'(-q);
         end
      end else begin
         if (q > {{(DIV_W-WORD_W){1'b0}}, 1'b0, {(WORD_W-1){1'b1}}}) begin
            r = WORD_MAX;
         end else begin
            r = q[WORD_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic logic signed [WORD_W-1:0] clamp_hi_lo(
         logic signed [WORD_W-1:0] v, logic signed [WORD_W-1:0] lo,
         logic signed [WORD_W-1:0] hi);
      logic signed [WORD_W-1:0] r;
      r = v;
      if (r > hi) begin
         r = hi;
      end
      if (r < lo) begin
         r = lo;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/gain_scheduled_pressure_regulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gain_scheduled_pressure_regulator
// Proportional pressure controller with gain and feedforward scheduled on
// pressurant pressure.
// ----------------------------------------------------------------------------
// One sample is accepted and one result leaves per cycle while the output is not
// stalled. Each sample passes the input register, the 40-stage pipelined divider
// (one quotient bit per stage), the post-processing registers and the output
// register. A two-entry output (register plus skid) lets the pipeline advance
// one more beat after a response beat stalls; once the skid is full the whole
// pipeline and the request side stall until a response beat is taken.
// Registers must be written only while no sample is in flight (not enforced).
module gain_scheduled_pressure_regulator
   import gspr_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [WORD_W-1:0]          csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [PRES_W-1:0]          req_tank_pressure,
   input  wire logic [PRES_W-1:0]          req_pressurant_pressure,
   input  wire logic [PRES_W-1:0]          req_pressure_setpoint,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [ANGLE_W-1:0]              rsp_valve_angle,
   output logic signed [WORD_W-1:0]        rsp_proportional_term
);

   cfg_type       cfg_ff;
   logic          s0_valid_ff;
   div_stage_type s0_ff;
   logic          en;
   logic          div_valid;
   div_stage_type div_stage;
   logic          post_valid;
   rsp_type       post_rsp;
   rsp_type       rsp_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_FF_BASE:  cfg_ff.ff_base  <= csr_write_data;
            REG_FF_ALPHA: cfg_ff.ff_alpha <= csr_write_data;
            REG_FF_MIN:   cfg_ff.ff_min   <= csr_write_data;
            REG_FF_MAX:   cfg_ff.ff_max   <= csr_write_data;
            REG_KP_BASE:  cfg_ff.kp_base  <= csr_write_data;
            REG_KP_BETA:  cfg_ff.kp_beta  <= csr_write_data;
            REG_KP_MIN:   cfg_ff.kp_min   <= csr_write_data;
            REG_KP_MAX:   cfg_ff.kp_max   <= csr_write_data;
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   // dividend magnitudes and pressure error
   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff.ff.rem     <= '0;
         s0_ff.ff.nq      <= coef_mag(cfg_ff.ff_alpha);
         s0_ff.kp.rem     <= '0;
         s0_ff.kp.nq      <= coef_mag(cfg_ff.kp_beta);
         s0_ff.side.pres  <= req_pressurant_pressure;
         s0_ff.side.err   <= ERR_W'({1'b0, req_pressure_setpoint})
                           - ERR_W'({1'b0, req_tank_pressure});
      end
   end

   gspr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_stage  (s0_ff),
      .out_valid (div_valid),
      .out_stage (div_stage)
   );

   gspr_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_stage  (div_stage),
      .out_valid (post_valid),
      .out_rsp   (post_rsp)
   );

   gspr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (post_valid),
      .in_rsp    (post_rsp),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_valve_angle       = rsp_beat.angle;
   assign rsp_proportional_term = rsp_beat.pterm;

endmodule
`default_nettype wire

### hw/rtl/gspr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gspr_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module gspr_div
   import gspr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire div_stage_type in_stage,
   output logic               out_valid,
   output div_stage_type      out_stage
);

   logic [DIV_W-1:0] valid_ff;
   div_stage_type    stage_ff [DIV_W];
   div_stage_type    stage_in [DIV_W];
   logic [DIV_W-1:0] valid_in;

   always_comb begin
      stage_in[0] = in_stage;
      valid_in[0] = in_valid;
      for (int k = 1; k < DIV_W; k++) begin
         stage_in[k] = stage_ff[k-1];
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_W; k++) begin
            stage_ff[k].ff   <= div_step(stage_in[k].ff, stage_in[k].side.pres);
            stage_ff[k].kp   <= div_step(stage_in[k].kp, stage_in[k].side.pres);
            stage_ff[k].side <= stage_in[k].side;
         end
      end
   end

   assign out_valid = valid_ff[DIV_W-1];
   assign out_stage = stage_ff[DIV_W-1];

endmodule
`default_nettype wire

### hw/rtl/gspr_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gspr_post
// Quotient saturation, scheduling clamps, proportional product and angle.
// ----------------------------------------------------------------------------
module gspr_post
   import gspr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire cfg_type       cfg,
   input  wire logic          in_valid,
   input  wire div_stage_type in_stage,
   output logic               out_valid,
   output rsp_type            out_rsp
);

   logic [6:0] valid_ff;

   logic signed [WORD_W-1:0] q_ff_ff, q_kp_ff, s_ff_ff, s_kp_ff, c_ff_ff, c_kp_ff;
   logic signed [ERR_W-1:0]  err1_ff, err2_ff, err3_ff;
   logic signed [WORD_W-1:0] ff4_ff, ff5_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WORD_W-1:0] pterm5_ff, pterm6_ff, pterm7_ff;
   logic signed [TEN_W-1:0]  tenths_ff;
   logic [ANGLE_W-1:0]       angle_ff;

   logic signed [PROD_W-9:0] prod_sh;
   logic signed [WORD_W-1:0] pterm_in;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [TEN_W-1:0]  tenths_in;
   logic [TEN_W-1:0]         mag;
   logic [TEN_W-17:0]        whole;
   logic [ANGLE_W-1:0]       angle_in;
   logic                     pres_zero;

   assign pres_zero = (in_stage.side.pres == '0);

   always_comb begin
      prod_sh = prod_ff[PROD_W-1:8];
      if (prod_sh > PROD_W'(WORD_MAX)) begin
         pterm_in = WORD_MAX;
      end else if (prod_sh < PROD_W'(WORD_MIN)) begin
         pterm_in = WORD_MIN;
      end else begin
         pterm_in = prod_sh[WORD_W-1:0];
      end
      sum_in    = SUM_W'(pterm5_ff) + SUM_W'(ff5_ff);
      tenths_in = (TEN_W'(sum_in) <<< 3) + (TEN_W'(sum_in) <<< 1);
      mag   = tenths_ff[TEN_W-1] ? TEN_W'(-tenths_ff) : TEN_W'(tenths_ff);
      whole = mag[TEN_W-1:16];
      if (tenths_ff[TEN_W-1] && whole != '0) begin
         angle_in = MIN_OPEN_ANGLE;
      end else begin
         if (whole > (TEN_W-16)'(MAX_OPEN_ANGLE)) begin
            angle_in = MAX_OPEN_ANGLE;
         end else begin
            angle_in = whole[ANGLE_W-1:0];
         end
         if (angle_in < MIN_OPEN_ANGLE) begin
            angle_in = MIN_OPEN_ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff_ff   <= sat_quo(in_stage.ff.nq, cfg.ff_alpha, pres_zero);
         q_kp_ff   <= sat_quo(in_stage.kp.nq, cfg.kp_beta, pres_zero);
         err1_ff   <= in_stage.side.err;
         s_ff_ff   <= sat_sum(SUM_W'(cfg.ff_base) + SUM_W'(q_ff_ff));
         s_kp_ff   <= sat_sum(SUM_W'(cfg.kp_base) + SUM_W'(q_kp_ff));
         err2_ff   <= err1_ff;
         c_ff_ff   <= clamp_hi_lo(s_ff_ff, cfg.ff_min, cfg.ff_max);
         c_kp_ff   <= clamp_hi_lo(s_kp_ff, cfg.kp_min, cfg.kp_max);
         err3_ff   <= err2_ff;
         prod_ff   <= PROD_W'(c_kp_ff) * PROD_W'(err3_ff);
         ff4_ff    <= c_ff_ff;
         pterm5_ff <= pterm_in;
         ff5_ff    <= ff4_ff;
         tenths_ff <= tenths_in;
         pterm6_ff <= pterm5_ff;
         angle_ff  <= angle_in;
         pterm7_ff <= pterm6_ff;
      end
   end

   assign out_valid     = valid_ff[6];
   assign out_rsp.angle = angle_ff;
   assign out_rsp.pterm = pterm7_ff;

endmodule
`default_nettype wire

### hw/rtl/gspr_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gspr_out
// Output register with a skid entry; freezes the pipeline when the skid fills.
// ----------------------------------------------------------------------------
module gspr_out
   import gspr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire rsp_type       in_rsp,
   output logic               en,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_beat
);

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;
   logic    push;

   assign en   = !skid_valid_ff;
   assign push = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_stall) begin
         if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_stall) begin
         if (push) begin
            skid_ff <= in_rsp;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (push) begin
         out_ff <= in_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output is empty");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_stall && skid_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid beat not moved to output");
   a_frozen_on_full: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_valid_ff && rsp_stall) |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid beat lost while stalled");
`endif

endmodule
`default_nettype wire

### sim/gspr_checker.sv
// ----------------------------------------------------------------------------
// gspr_checker
// Follows register writes and both channels of the regulator. For each
// accepted request beat it computes the expected valve angle and proportional
// term. Each response beat is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module gspr_checker
   import gspr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [2:0]           csr_index,
   input  wire logic [WORD_W-1:0]    csr_write_data,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic [PRES_W-1:0]    req_tank_pressure,
   input  wire logic [PRES_W-1:0]    req_pressurant_pressure,
   input  wire logic [PRES_W-1:0]    req_pressure_setpoint,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [ANGLE_W-1:0]   rsp_valve_angle,
   input  wire logic signed [WORD_W-1:0] rsp_proportional_term,
   output int                        failures,
   output int                        outstanding
);

   cfg_type settings;
   rsp_type pending_outputs[$];

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // base plus coefficient over pressurant, saturated then clamped
   function automatic longint scheduled_term(longint base, longint coef, longint lo,
         longint hi, longint pres);
      longint q;
      longint s;
      if (pres == 0) begin
         q = (coef > 0) ? 64'sd2147483647 : ((coef < 0) ? -64'sd2147483648 : 0);
      end else begin
         q = sat_word((coef * 256) / pres);
      end
      s = sat_word(base + q);
      if (s > hi) begin
         s = hi;
      end
      if (s < lo) begin
         s = lo;
      end
      return s;
   endfunction

   function automatic rsp_type regulate(cfg_type c, logic [PRES_W-1:0] tank,
         logic [PRES_W-1:0] pres, logic [PRES_W-1:0] setp);
      longint ff;
      longint kp;
      longint err;
      longint pt;
      longint tenths;
      longint ang;
      rsp_type r;
      ff = scheduled_term(longint'(c.ff_base), longint'(c.ff_alpha), longint'(c.ff_min),
         longint'(c.ff_max), longint'(pres));
      kp = scheduled_term(longint'(c.kp_base), longint'(c.kp_beta), longint'(c.kp_min),
         longint'(c.kp_max), longint'(pres));
      err = longint'(setp) - longint'(tank);
      pt = sat_word((kp * err) >>> 8);
      tenths = (pt + ff) * 10;
      ang = tenths / 65536;
      if (ang < 0) begin
         ang = longint'(MIN_OPEN_ANGLE);
      end else begin
         if (ang > longint'(MAX_OPEN_ANGLE)) begin
            ang = longint'(MAX_OPEN_ANGLE);
         end
         if (ang < longint'(MIN_OPEN_ANGLE)) begin
            ang = longint'(MIN_OPEN_ANGLE);
         end
      end
      r.angle = ang[ANGLE_W-1:0];
      r.pterm = pt[WORD_W-1:0];
      return r;
   endfunction

   assign outstanding = pending_outputs.size();

   initial begin
      failures = 0;
      settings = '0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         settings = '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               REG_FF_BASE:  settings.ff_base  = csr_write_data;
               REG_FF_ALPHA: settings.ff_alpha = csr_write_data;
               REG_FF_MIN:   settings.ff_min   = csr_write_data;
               REG_FF_MAX:   settings.ff_max   = csr_write_data;
               REG_KP_BASE:  settings.kp_base  = csr_write_data;
               REG_KP_BETA:  settings.kp_beta  = csr_write_data;
               REG_KP_MIN:   settings.kp_min   = csr_write_data;
               REG_KP_MAX:   settings.kp_max   = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_outputs.push_back(regulate(settings, req_tank_pressure,
               req_pressurant_pressure, req_pressure_setpoint));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outputs.size() == 0) begin
               $error("unexpected response beat");
               failures++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_valve_angle !== want.angle) begin
                  $error("valve_angle expected %0d actual %0d", want.angle,
                     rsp_valve_angle);
                  failures++;
               end
               if (rsp_proportional_term !== want.pterm) begin
                  $error("proportional_term expected %0d actual %0d", want.pterm,
                     rsp_proportional_term);
                  failures++;
               end
            end
         end
      end
   end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the gain scheduled pressure regulator through a series of register
// settings, directed corner samples and random sample streams, with random
// gaps and stalls and one long response hold-off; the checker does the
// comparison.
// ----------------------------------------------------------------------------
module tb;
   import gspr_pkg::*;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [2:0]                 csr_index;
   logic [WORD_W-1:0]          csr_write_data;
   logic                       req_valid;
   logic                       req_stall;
   logic [PRES_W-1:0]          req_tank_pressure;
   logic [PRES_W-1:0]          req_pressurant_pressure;
   logic [PRES_W-1:0]          req_pressure_setpoint;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ANGLE_W-1:0]         rsp_valve_angle;
   logic signed [WORD_W-1:0]   rsp_proportional_term;
   int                         failures;
   int                         outstanding;
   bit                         steady_stream;

   gain_scheduled_pressure_regulator dut (.*);
   gspr_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_stream || roll < 70) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls plus one long hold-off
   initial begin
      int cycle;
      int hold;
      rsp_stall = 1'b1;
      cycle = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle == 3000) begin
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (steady_stream) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 25);
            if ($urandom_range(0, 199) == 0) begin
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   task automatic write_settings(input logic [WORD_W-1:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= 3'(i);
         csr_write_data <= vals[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_sample(input logic [PRES_W-1:0] tank, input logic [PRES_W-1:0] pres,
         input logic [PRES_W-1:0] setp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_tank_pressure <= tank;
      req_pressurant_pressure <= pres;
      req_pressure_setpoint <= setp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (60) @(negedge clock);
   endtask

   task automatic corner_samples();
      send_sample(24'h000000, 24'h000000, 24'h000000);
      send_sample(24'hffffff, 24'hffffff, 24'hffffff);
      send_sample(24'h000000, 24'h000000, 24'hffffff);
      send_sample(24'hffffff, 24'h000000, 24'h000000);
      send_sample(24'hffffff, 24'h000001, 24'h000000);
      send_sample(24'h000000, 24'h000001, 24'hffffff);
   endtask

   task automatic random_samples(input int count);
      int mode;
      int tank;
      int pres;
      int setp;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 2) begin
            tank = $urandom_range(0, 24'hffffff);
            pres = $urandom_range(0, 24'hffffff);
            setp = $urandom_range(0, 24'hffffff);
         end else begin
            tank = $urandom_range(0, 24'hffffff);
            setp = tank + $urandom_range(0, 32768) - 16384;
            if (setp < 0) begin
               setp = 0;
            end
            if (setp > 24'hffffff) begin
               setp = 24'hffffff;
            end
            pres = (mode == 2) ? 0 : $urandom_range(1, (mode < 6) ? 8192 : 24'hffffff);
         end
         send_sample(tank[23:0], pres[23:0], setp[23:0]);
      end
   endtask

   initial begin
      logic [WORD_W-1:0] vals[8];
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_tank_pressure = '0;
      req_pressurant_pressure = '0;
      req_pressure_setpoint = '0;
      steady_stream = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values
      corner_samples();
      drain();

      // all registers at the top of their range
      foreach (vals[i]) vals[i] = 32'h7fffffff;
      write_settings(vals);
      corner_samples();
      drain();

      // all registers at the bottom of their range
      foreach (vals[i]) vals[i] = 32'h80000000;
      write_settings(vals);
      corner_samples();
      random_samples(50);
      drain();

      // plausible schedule, in range angles
      vals = '{32'd40 << 16, 32'd100 << 16, 32'd0, 32'd80 << 16,
               32'd2 << 16, 32'd50 << 16, 32'd0, 32'd10 << 16};
      write_settings(vals);
      random_samples(500);
      drain();

      // negative gain, crossed feedforward bounds
      vals = '{32'd20 << 16, -(32'd30 << 16), 32'd60 << 16, 32'd10 << 16,
               -(32'd3 << 16), 32'd20 << 16, -(32'd8 << 16), 32'd0};
      write_settings(vals);
      random_samples(250);
      drain();

      // crossed gain bounds, back-to-back stream
      steady_stream = 1'b1;
      vals = '{32'd5 << 16, 32'd10 << 16, -(32'd20 << 16), 32'd90 << 16,
               32'd4 << 16, -(32'd40 << 16), 32'd6 << 16, 32'd1 << 16};
      write_settings(vals);
      random_samples(200);
      drain();
      steady_stream = 1'b0;

      for (int k = 0; k < 5; k++) begin
         foreach (vals[i]) begin
            vals[i] = (k < 2) ? $urandom() : ($urandom_range(0, 32'h00ffffff) - 32'h00800000);
         end
         write_settings(vals);
         random_samples(150);
         drain();
      end

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
